@@ design/bbpg_pkg.sv @@
package bbpg_pkg;

  localparam int TIME_BITS_DEF = 16;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] ENDLESS_COUNT = 8'hFF;

  typedef struct packed {
    logic [1:0]  command;
    logic        always_on;
    logic [7:0]  request_priority;
    logic [7:0]  beep_count;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
  } item_t;

  typedef struct packed {
    logic       buzzer_level;
    logic [7:0] beeps_left;
  } result_t;

  typedef struct packed {
    logic       endless_mode;
    logic       level;
    logic [7:0] remaining;
  } status_t;

endpackage

@@ design/bbpg_in_if.sv @@
interface bbpg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        always_on;
  logic [7:0]  request_priority;
  logic [7:0]  beep_count;
  logic [15:0] on_ticks;
  logic [15:0] off_ticks;

  modport source (
    output valid, command, always_on, request_priority, beep_count, on_ticks, off_ticks,
    input  ready
  );
  modport sink (
    input  valid, command, always_on, request_priority, beep_count, on_ticks, off_ticks,
    output ready
  );
endinterface

@@ design/bbpg_out_if.sv @@
interface bbpg_out_if;
  logic       valid;
  logic       ready;
  logic       buzzer_level;
  logic [7:0] beeps_left;

  modport source (
    output valid, buzzer_level, beeps_left,
    input  ready
  );
  modport sink (
    input  valid, buzzer_level, beeps_left,
    output ready
  );
endinterface

@@ design/bbpg_core.sv @@
module bbpg_core #(
  parameter int TIME_BITS = bbpg_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  bbpg_pkg::item_t   item,
  input  logic [7:0]        base_priority,
  output bbpg_pkg::result_t result,
  output bbpg_pkg::status_t status
);

  logic                 endless_r, endless_nxt;
  logic [7:0]           rem_r, rem_nxt;
  logic                 level_r, level_nxt;
  logic [TIME_BITS-1:0] on_period_r, on_period_nxt;
  logic [TIME_BITS-1:0] off_period_r, off_period_nxt;
  logic [TIME_BITS-1:0] since_on_r, since_on_nxt;
  logic [TIME_BITS-1:0] since_off_r, since_off_nxt;

  logic [TIME_BITS-1:0] on_t, off_t, son_inc, soff_inc;
  logic                 low_take, high_take;

  assign on_t      = TIME_BITS'(item.on_ticks);
  assign off_t     = TIME_BITS'(item.off_ticks);
  assign son_inc   = (since_on_r == '1) ? since_on_r : since_on_r + TIME_BITS'(1);
  assign soff_inc  = (since_off_r == '1) ? since_off_r : since_off_r + TIME_BITS'(1);
  assign low_take  = (item.request_priority <= base_priority) && (rem_r == 8'd0);
  assign high_take = item.request_priority > base_priority;

  always_comb begin
    endless_nxt    = endless_r;
    rem_nxt        = rem_r;
    level_nxt      = level_r;
    on_period_nxt  = on_period_r;
    off_period_nxt = off_period_r;
    since_on_nxt   = since_on_r;
    since_off_nxt  = since_off_r;
    unique case (item.command)
      bbpg_pkg::CMD_TICK: begin
        since_on_nxt  = son_inc;
        since_off_nxt = soff_inc;
        if (level_r && (son_inc >= on_period_r)) begin
          level_nxt     = 1'b0;
          since_off_nxt = '0;
        end
        if (!level_nxt && (since_off_nxt >= off_period_r)) begin
          if (endless_r) begin
            level_nxt    = 1'b1;
            since_on_nxt = '0;
          end else if (rem_r != 8'd0) begin
            level_nxt    = 1'b1;
            since_on_nxt = '0;
            rem_nxt      = rem_r - 8'd1;
          end
        end
      end
      bbpg_pkg::CMD_START: begin
        if (low_take || high_take) begin
          endless_nxt    = item.always_on;
          on_period_nxt  = on_t;
          off_period_nxt = off_t;
          since_on_nxt   = '0;
          if (low_take && item.always_on) begin
            rem_nxt = bbpg_pkg::ENDLESS_COUNT;
          end else if (item.beep_count != 8'd0) begin
            level_nxt = 1'b1;
            rem_nxt   = item.beep_count - 8'd1;
          end else begin
            rem_nxt = 8'd0;
          end
        end
      end
      bbpg_pkg::CMD_CLEAR: begin
        endless_nxt    = 1'b0;
        rem_nxt        = 8'd0;
        level_nxt      = 1'b0;
        on_period_nxt  = '0;
        off_period_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      endless_r    <= 1'b0;
      rem_r        <= 8'd0;
      level_r      <= 1'b0;
      on_period_r  <= '0;
      off_period_r <= '0;
      since_on_r   <= '0;
      since_off_r  <= '0;
    end else if (en) begin
      endless_r    <= endless_nxt;
      rem_r        <= rem_nxt;
      level_r      <= level_nxt;
      on_period_r  <= on_period_nxt;
      off_period_r <= off_period_nxt;
      since_on_r   <= since_on_nxt;
      since_off_r  <= since_off_nxt;
    end
  end

  assign result.buzzer_level = level_nxt;
  assign result.beeps_left   = rem_nxt;
  assign status.endless_mode = endless_r;
  assign status.level        = level_r;
  assign status.remaining    = rem_r;

endmodule

@@ design/buzzer_beep_pattern_generator.sv @@
// Buzzer beep pattern generator. Each in_chan item (tick, start request, clear or unused no-op)
// yields exactly one out_chan transaction with the buzzer level and remaining beep count after
// it. One item is taken per clock cycle unless out_chan stalls; a result passes through the
// input register, then the state update into the result register, and that state update loop
// sets the rate. in_chan stays ready while a result waits, until both the input and result
// registers are full. The user must write base_priority through cfg_we/cfg_wdata only while
// the block is idle, which it does not enforce. TIME_BITS sets the width of the tick timers.
module buzzer_beep_pattern_generator #(
  parameter int TIME_BITS = bbpg_pkg::TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bbpg_in_if.sink    in_chan,
  bbpg_out_if.source out_chan,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic              in_v_r;
  bbpg_pkg::item_t   in_item_r;
  logic              out_v_r;
  bbpg_pkg::result_t out_res_r;
  logic [7:0]        base_prio_r;
  logic              advance;
  bbpg_pkg::result_t core_res;
  bbpg_pkg::status_t core_stat;

  assign advance       = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_prio_r <= 8'd0;
    end else if (cfg_we) begin
      base_prio_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_r.command          <= in_chan.command;
      in_item_r.always_on        <= in_chan.always_on;
      in_item_r.request_priority <= in_chan.request_priority;
      in_item_r.beep_count       <= in_chan.beep_count;
      in_item_r.on_ticks         <= in_chan.on_ticks;
      in_item_r.off_ticks        <= in_chan.off_ticks;
    end
  end

  bbpg_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (advance),
    .item         (in_item_r),
    .base_priority(base_prio_r),
    .result       (core_res),
    .status       (core_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.buzzer_level = out_res_r.buzzer_level;
  assign out_chan.beeps_left   = out_res_r.beeps_left;

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.command == bbpg_pkg::CMD_CLEAR) |=>
      (out_chan.valid && !out_chan.buzzer_level && out_chan.beeps_left == 8'd0))
    else $error("clear did not report an idle buzzer");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (in_v_r && out_v_r && !out_chan.ready))
    else $error("input stalled without a full pipeline");

  a_endless_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.command == bbpg_pkg::CMD_TICK && core_stat.endless_mode) |=>
      (out_chan.beeps_left == $past(core_stat.remaining)))
    else $error("endless tick changed the beep count");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance) |-> (out_chan.buzzer_level == core_stat.level &&
                        out_chan.beeps_left == core_stat.remaining))
    else $error("result register disagrees with state");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 6;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  bbpg_in_if  in_chan();
  bbpg_out_if out_chan();

  buzzer_beep_pattern_generator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predicted buzzer state
  logic [7:0]  prio_floor;
  logic        endless_on;
  logic        drive_on;
  logic [7:0]  beeps_pending;
  logic [15:0] on_len;
  logic [15:0] off_len;
  logic [15:0] ticks_since_on;
  logic [15:0] ticks_since_off;

  bbpg_pkg::result_t beep_status_q[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic [15:0] sat_up(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bbpg_pkg::result_t buzzer_next(input bbpg_pkg::item_t t);
    bbpg_pkg::result_t r;
    case (t.command)
      bbpg_pkg::CMD_TICK: begin
        ticks_since_on  = sat_up(ticks_since_on);
        ticks_since_off = sat_up(ticks_since_off);
        if (drive_on && ticks_since_on >= on_len) begin
          drive_on        = 1'b0;
          ticks_since_off = '0;
        end
        if (!drive_on && ticks_since_off >= off_len) begin
          if (endless_on) begin
            drive_on       = 1'b1;
            ticks_since_on = '0;
          end else if (beeps_pending != 8'd0) begin
            drive_on       = 1'b1;
            ticks_since_on = '0;
            beeps_pending  = beeps_pending - 8'd1;
          end
        end
      end
      bbpg_pkg::CMD_START: begin
        if (t.request_priority <= prio_floor && beeps_pending == 8'd0) begin
          endless_on     = t.always_on;
          beeps_pending  = t.always_on ? bbpg_pkg::ENDLESS_COUNT : t.beep_count;
          on_len         = t.on_ticks;
          off_len        = t.off_ticks;
          ticks_since_on = '0;
          if (beeps_pending != 8'd0 && !t.always_on) begin
            drive_on      = 1'b1;
            beeps_pending = beeps_pending - 8'd1;
          end
        end else if (t.request_priority > prio_floor) begin
          endless_on     = t.always_on;
          beeps_pending  = t.beep_count;
          on_len         = t.on_ticks;
          off_len        = t.off_ticks;
          ticks_since_on = '0;
          if (beeps_pending != 8'd0) begin
            drive_on      = 1'b1;
            beeps_pending = beeps_pending - 8'd1;
          end
        end
      end
      bbpg_pkg::CMD_CLEAR: begin
        endless_on    = 1'b0;
        beeps_pending = '0;
        on_len        = '0;
        off_len       = '0;
        drive_on      = 1'b0;
      end
      default: ;
    endcase
    r.buzzer_level = drive_on;
    r.beeps_left   = beeps_pending;
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    bbpg_pkg::result_t want;
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (beep_status_q.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual level=%0b left=%0d",
                 $time, out_chan.buzzer_level, out_chan.beeps_left);
        errors++;
      end else begin
        want = beep_status_q.pop_front();
        if (out_chan.buzzer_level !== want.buzzer_level) begin
          $display("%0t: buzzer_level mismatch: expected %0b actual %0b",
                   $time, want.buzzer_level, out_chan.buzzer_level);
          errors++;
        end
        if (out_chan.beeps_left !== want.beeps_left) begin
          $display("%0t: beeps_left mismatch: expected %0d actual %0d",
                   $time, want.beeps_left, out_chan.beeps_left);
          errors++;
        end
      end
    end
  end

  function automatic bbpg_pkg::item_t mk_item(input logic [1:0] cmd, input logic aon,
                                              input logic [7:0] prio, input logic [7:0] cnt,
                                              input logic [15:0] on_t,
                                              input logic [15:0] off_t);
    bbpg_pkg::item_t t;
    t.command          = cmd;
    t.always_on        = aon;
    t.request_priority = prio;
    t.beep_count       = cnt;
    t.on_ticks         = on_t;
    t.off_ticks        = off_t;
    return t;
  endfunction

  task automatic send_txn(input bbpg_pkg::item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.command          <= t.command;
    in_chan.always_on        <= t.always_on;
    in_chan.request_priority <= t.request_priority;
    in_chan.beep_count       <= t.beep_count;
    in_chan.on_ticks         <= t.on_ticks;
    in_chan.off_ticks        <= t.off_ticks;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    beep_status_q.push_back(buzzer_next(t));
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (beep_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base_priority(input logic [7:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    prio_floor  = v;
  endtask

  task automatic test_directed();
    send_txn(mk_item(bbpg_pkg::CMD_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0));
    send_txn(mk_item(CMD_UNUSED, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    write_base_priority(8'd100);
    // low priority start, then a full on/off cycle
    send_txn(mk_item(bbpg_pkg::CMD_START, 1'b0, 8'd50, 8'd3, 16'd1, 16'd1));
    send_txn(mk_item(bbpg_pkg::CMD_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0));
    send_txn(mk_item(bbpg_pkg::CMD_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0));
    // at base priority with beeps pending: rejected
    send_txn(mk_item(bbpg_pkg::CMD_START, 1'b0, 8'd100, 8'd9, 16'd4, 16'd4));
    // preempt with a zero count: level held
    send_txn(mk_item(bbpg_pkg::CMD_START, 1'b0, 8'd101, 8'd0, 16'd0, 16'd0));
    send_txn(mk_item(bbpg_pkg::CMD_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0));
    // off and back on within one tick
    send_txn(mk_item(bbpg_pkg::CMD_START, 1'b0, 8'hFF, 8'hFF, 16'd0, 16'd0));
    send_txn(mk_item(bbpg_pkg::CMD_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0));
    send_txn(mk_item(bbpg_pkg::CMD_CLEAR, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0));
    // endless, low and high priority
    send_txn(mk_item(bbpg_pkg::CMD_START, 1'b1, 8'd0, 8'd5, 16'd2, 16'hFFFF));
    send_txn(mk_item(bbpg_pkg::CMD_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0));
    send_txn(mk_item(bbpg_pkg::CMD_START, 1'b1, 8'd200, 8'd0, 16'd0, 16'd0));
    repeat (3) send_txn(mk_item(bbpg_pkg::CMD_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0));
    send_txn(mk_item(bbpg_pkg::CMD_START, 1'b1, 8'd200, 8'd7, 16'hFFFF, 16'd0));
    send_txn(mk_item(bbpg_pkg::CMD_START, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0));
    send_txn(mk_item(bbpg_pkg::CMD_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0));
    send_txn(mk_item(bbpg_pkg::CMD_CLEAR, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_txn(mk_item(bbpg_pkg::CMD_START, 1'b0, 8'd100, 8'd0, 16'd3, 16'd3));
    send_txn(mk_item(bbpg_pkg::CMD_START, 1'b0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_txn(mk_item(bbpg_pkg::CMD_CLEAR, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0));
  endtask

  function automatic bbpg_pkg::item_t rand_item();
    bbpg_pkg::item_t t;
    int    sel;
    sel                = $urandom_range(99);
    t.always_on        = ($urandom_range(99) < 15);
    t.request_priority = 8'($urandom_range(255));
    t.beep_count       = 8'($urandom_range(255));
    t.on_ticks         = 16'($urandom_range(65535));
    t.off_ticks        = 16'($urandom_range(65535));
    if (sel < 55) t.command = bbpg_pkg::CMD_TICK;
    else if (sel < 85) t.command = bbpg_pkg::CMD_START;
    else if (sel < 93) t.command = bbpg_pkg::CMD_CLEAR;
    else t.command = CMD_UNUSED;
    if (t.command == bbpg_pkg::CMD_START) begin
      if ($urandom_range(1) == 0)
        t.request_priority = prio_floor + 8'($urandom_range(2)) - 8'd1;
      if ($urandom_range(99) < 70) t.beep_count = 8'($urandom_range(6));
      if ($urandom_range(99) < 80) t.on_ticks = 16'($urandom_range(5));
      if ($urandom_range(99) < 80) t.off_ticks = 16'($urandom_range(5));
    end
    return t;
  endfunction

  task automatic test_random_traffic(input logic [7:0] base, input int n);
    write_base_priority(base);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 || $urandom_range(99) == 0) drain_results();
      send_txn(rand_item());
    end
  endtask

  initial begin
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_wdata                = '0;
    in_chan.valid            = 1'b0;
    in_chan.command          = bbpg_pkg::CMD_TICK;
    in_chan.always_on        = 1'b0;
    in_chan.request_priority = '0;
    in_chan.beep_count       = '0;
    in_chan.on_ticks         = '0;
    in_chan.off_ticks        = '0;
    out_chan.ready           = 1'b0;
    prio_floor               = '0;
    endless_on               = 1'b0;
    drive_on                 = 1'b0;
    beeps_pending            = '0;
    on_len                   = '0;
    off_len                  = '0;
    ticks_since_on           = '0;
    ticks_since_off          = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 71;
    test_directed();
    test_random_traffic(8'd0, 160);
    test_random_traffic(8'hFF, 160);

    send_idle_pct = 71;
    recv_idle_pct = 38;
    test_random_traffic(8'd128, 150);
    test_random_traffic(8'($urandom_range(255)), 150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(8'd1, 160);
    test_random_traffic(8'd254, 160);

    drain_results();
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
